[hdl/lba2chs_pkg.sv]
// Package for the logical block address to cylinder/head/sector converter.
// Holds widths, register indexes, reset geometry and the divider step function.
// Depends on nothing.
package lba2chs_pkg;

  localparam int ADDR_W         = 32;
  localparam int GEOM_W         = 8;
  localparam int BITS_PER_STAGE = 4;
  localparam int STAGES_PER_DIV = ADDR_W / BITS_PER_STAGE;
  localparam int NUM_STAGES     = 2 * STAGES_PER_DIV;

  // Configuration register indexes.
  localparam logic REG_SECTORS_PER_TRACK  = 1'b0;
  localparam logic REG_HEADS_PER_CYLINDER = 1'b1;

  // Geometry after reset.
  localparam logic [GEOM_W-1:0] SECTORS_PER_TRACK_RESET  = 8'd63;
  localparam logic [GEOM_W-1:0] HEADS_PER_CYLINDER_RESET = 8'd16;

  // Partial state of a restoring divider: the work word shifts the dividend
  // out at the top and the quotient in at the bottom.
  typedef struct packed {
    logic [ADDR_W-1:0] work;
    logic [GEOM_W-1:0] rem;
  } div_state_t;

  // Resolve BITS_PER_STAGE quotient bits. For a nonzero divisor the trial
  // value stays below twice the divisor, so the remainder fits GEOM_W bits.
  function automatic div_state_t div_step(input div_state_t state_in,
                                          input logic [GEOM_W-1:0] divisor);
    div_state_t      res;
    logic [GEOM_W:0] trial;
    int              i;
    res = state_in;
    for (i = 0; i < BITS_PER_STAGE; i++) begin
      trial    = {res.rem, res.work[ADDR_W-1]};
      res.work = {res.work[ADDR_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        res.rem     = GEOM_W'(trial - {1'b0, divisor});
        res.work[0] = 1'b1;
      end else begin
        res.rem = trial[GEOM_W-1:0];
      end
    end
    return res;
  endfunction

endpackage

[hdl/lba_to_chs_converter.sv]
// Top level of the logical block address to cylinder/head/sector converter.
// Holds the geometry registers and the sixteen stage divider pipeline.
// Depends on lba2chs_pkg.

// The converter accepts one address per clock while lba_stall is low and
// returns results in order. The first eight stages divide the address by
// sectors per track and the next eight divide the track index by heads per
// cylinder; each stage resolves four quotient bits of a restoring divider.
// When the result at the output is stalled, the whole pipeline holds and
// lba_stall is raised in the same cycle. Geometry is read live, so the user
// must write it only while the block is idle; the block does not enforce
// this. A zero geometry value yields geometry_error with zero fields.
module lba_to_chs_converter
  import lba2chs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Configuration write port.
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [GEOM_W-1:0] cfg_data,
  // Request channel.
  input  logic              lba_valid,
  output logic              lba_stall,
  input  logic [ADDR_W-1:0] logical_block,
  // Result channel.
  output logic              chs_valid,
  input  logic              chs_stall,
  output logic [ADDR_W-1:0] cylinder,
  output logic [GEOM_W-1:0] head,
  output logic [GEOM_W-1:0] sector,
  output logic              geometry_error
);

  logic [GEOM_W-1:0] sectors_per_track;
  logic [GEOM_W-1:0] heads_per_cylinder;

  logic              vld  [NUM_STAGES];
  div_state_t        div  [NUM_STAGES];
  logic [GEOM_W-1:0] srem [NUM_STAGES];

  logic advance;

  // Geometry registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sectors_per_track  <= SECTORS_PER_TRACK_RESET;
      heads_per_cylinder <= HEADS_PER_CYLINDER_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SECTORS_PER_TRACK:  sectors_per_track  <= cfg_data;
        REG_HEADS_PER_CYLINDER: heads_per_cylinder <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the last stage is empty or being taken.
  assign advance   = !(vld[NUM_STAGES-1] && chs_stall);
  assign lba_stall = !advance;

  // Divider stages.
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    div_state_t        src;
    logic [GEOM_W-1:0] src_srem;
    logic              src_vld;
    logic [GEOM_W-1:0] divisor;

    // Select the stage input: a new address, the track index entering the
    // second division, or the previous stage.
    if (s == 0) begin : g_entry
      always_comb begin
        src.work = logical_block;
        src.rem  = '0;
        src_srem = '0;
        src_vld  = lba_valid;
      end
    end else if (s == STAGES_PER_DIV) begin : g_track
      always_comb begin
        src.work = div[s-1].work;
        src.rem  = '0;
        src_srem = div[s-1].rem;
        src_vld  = vld[s-1];
      end
    end else begin : g_chain
      always_comb begin
        src      = div[s-1];
        src_srem = srem[s-1];
        src_vld  = vld[s-1];
      end
    end

    assign divisor = (s < STAGES_PER_DIV) ? sectors_per_track : heads_per_cylinder;

    // Valid bit of the stage.
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (advance) begin
        vld[s] <= src_vld;
      end
    end

    // Payload of the stage.
    always_ff @(posedge clk) begin
      if (advance) begin
        div[s]  <= div_step(src, divisor);
        srem[s] <= src_srem;
      end
    end
  end

  // Result fields from the last stage.
  assign chs_valid      = vld[NUM_STAGES-1];
  assign geometry_error = (sectors_per_track == '0) || (heads_per_cylinder == '0);
  assign cylinder       = geometry_error ? '0 : div[NUM_STAGES-1].work;
  assign head           = geometry_error ? '0 : div[NUM_STAGES-1].rem;
  assign sector         = geometry_error ? '0 : GEOM_W'(srem[NUM_STAGES-1] + 1'b1);

  // A valid head is always below the head count.
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    chs_valid && !geometry_error |-> head < heads_per_cylinder)
    else $error("head out of range");

  // A valid sector is one-based and within the track.
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    chs_valid && !geometry_error |-> sector != '0 && sector <= sectors_per_track)
    else $error("sector out of range");

  // A stalled result is not lost by the pipeline.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    vld[NUM_STAGES-1] && chs_stall |=> vld[NUM_STAGES-1])
    else $error("stalled result dropped");

  // A request refused at the input does not enter the first stage.
  a_refuse_holds: assert property (@(posedge clk) disable iff (rst)
    lba_stall && !vld[0] |=> !vld[0])
    else $error("refused request entered the pipeline");

endmodule
